// File: hdl/asf_pkg.sv
// Shared types, constants and NTC tables for the converter scan, filter and conversion block.
// No dependencies; every other file in hdl imports this package.

package asf_pkg;

    // Field widths and scan geometry.
    localparam int SAMPLE_W     = 12;
    localparam int NUM_CHANNELS = 5;
    localparam int SCAN_W       = $clog2(NUM_CHANNELS);
    localparam int CH_OUT_W     = 3;
    localparam int SEL_W        = 5;
    localparam int FILT_SHIFT   = 3;
    localparam int ACC_W        = SAMPLE_W + FILT_SHIFT;
    localparam int TEMP_SHIFT   = 4;
    localparam int TEMP_W       = 14;
    localparam int MEAS_W       = 16;

    // Configuration register widths.
    localparam int FS_W      = 10;
    localparam int OHM_W     = 20;
    localparam int SUM_W     = OHM_W + 1;
    localparam int CFG_IDX_W = 3;

    // Serial arithmetic units.
    localparam int MPLIER_W     = 10;
    localparam int PROD_W       = SUM_W + MPLIER_W;
    localparam int MUL_CNT_W    = $clog2(MPLIER_W + 1);
    localparam int QUO_W        = 16;
    localparam int COUNT_W      = 12;
    localparam int TENTHS_W     = 10;
    localparam int SHORT_QUO_W  = TENTHS_W;
    localparam int SHORT_REM_HI = COUNT_W + SHORT_QUO_W;
    localparam int DIV_CNT_W    = $clog2(QUO_W + 1);

    // NTC table.
    localparam int TABLE_POINTS = 21;
    localparam int SEG_W        = $clog2(TABLE_POINTS);
    localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(TABLE_POINTS - 1);

    localparam logic [SCAN_W-1:0] SUPPLY_CHANNEL = SCAN_W'(4);
    localparam logic [SCAN_W-1:0] LAST_CHANNEL   = SCAN_W'(NUM_CHANNELS - 1);
    localparam logic [MEAS_W-1:0] MEAS_MAX       = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUP_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUP_BOTTOM = 3'd4;

    // Configuration reset values.
    localparam logic [FS_W-1:0]  RST_FULL_SCALE = 10'd330;
    localparam logic [OHM_W-1:0] RST_DIM_TOP    = 20'd80600;
    localparam logic [OHM_W-1:0] RST_DIM_BOTTOM = 20'd12000;
    localparam logic [OHM_W-1:0] RST_SUP_TOP    = 20'd33000;
    localparam logic [OHM_W-1:0] RST_SUP_BOTTOM = 20'd10000;

    localparam logic [COUNT_W-1:0] NTC_COUNTS [TABLE_POINTS] = '{
        12'd1070, 12'd1255, 12'd1450, 12'd1649, 12'd1850, 12'd2048, 12'd2241,
        12'd2426, 12'd2598, 12'd2758, 12'd2903, 12'd3035, 12'd3154, 12'd3260,
        12'd3354, 12'd3437, 12'd3511, 12'd3575, 12'd3632, 12'd3683, 12'd3727
    };

    localparam logic [TENTHS_W-1:0] NTC_TENTHS [TABLE_POINTS] = '{
        10'd0,   10'd50,  10'd100, 10'd150, 10'd200, 10'd250, 10'd300,
        10'd350, 10'd400, 10'd450, 10'd500, 10'd550, 10'd600, 10'd650,
        10'd700, 10'd750, 10'd800, 10'd850, 10'd900, 10'd950, 10'd1000
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_INTERP_MUL,
        ST_INTERP_DIV,
        ST_TEMP,
        ST_VOLT_MUL1,
        ST_VOLT_MUL2,
        ST_VOLT_DIV,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic                start;
        logic [SUM_W-1:0]    mcand;
        logic [MPLIER_W-1:0] mplier;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] product;
    } t_mul_rsp;

    typedef struct packed {
        logic              start;
        logic              short_quo;
        logic [PROD_W-1:0] dividend;
        logic [OHM_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } t_div_rsp;

    // Table reads past the last point return the last point.
    function automatic logic [COUNT_W-1:0] ntc_count(input logic [SEG_W-1:0] idx);
        if (idx < SEG_W'(TABLE_POINTS - 1)) begin
            return NTC_COUNTS[idx];
        end
        return NTC_COUNTS[TABLE_POINTS-1];
    endfunction

    function automatic logic [TENTHS_W-1:0] ntc_tenths(input logic [SEG_W-1:0] idx);
        if (idx < SEG_W'(TABLE_POINTS - 1)) begin
            return NTC_TENTHS[idx];
        end
        return NTC_TENTHS[TABLE_POINTS-1];
    endfunction

endpackage

// File: hdl/asf_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on asf_pkg for widths and the request and response structs.

module asf_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  asf_pkg::t_mul_req i_req,
    output asf_pkg::t_mul_rsp o_rsp
);
    import asf_pkg::*;

    logic [PROD_W-1:0]    r_acc;
    logic [PROD_W-1:0]    n_acc;
    logic [SUM_W-1:0]     r_mcand;
    logic [MPLIER_W-1:0]  r_mplier;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_done;

    always_comb begin
        n_acc = {r_acc[PROD_W-2:0], 1'b0} +
                (r_mplier[MPLIER_W-1] ? PROD_W'(r_mcand) : PROD_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == MUL_CNT_W'(1)) && !i_req.start;
            if (i_req.start) begin
                r_cnt <= MUL_CNT_W'(MPLIER_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - MUL_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc    <= '0;
            r_mcand  <= i_req.mcand;
            r_mplier <= i_req.mplier;
        end else if (r_cnt != '0) begin
            r_acc    <= n_acc;
            r_mplier <= {r_mplier[MPLIER_W-2:0], 1'b0};
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

// File: hdl/asf_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, 16 or 10 quotient bits.
// Depends on asf_pkg for widths and the request and response structs.

module asf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  asf_pkg::t_div_req i_req,
    output asf_pkg::t_div_rsp o_rsp
);
    import asf_pkg::*;

    logic [OHM_W-1:0]     r_rem;
    logic [OHM_W-1:0]     r_divisor;
    logic [QUO_W-1:0]     r_bits;
    logic [QUO_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;

    logic [OHM_W:0]   n_trial;
    logic [OHM_W:0]   n_diff;
    logic             n_ge;
    logic [OHM_W-1:0] n_rem;

    // The remainder always stays below the divisor, so the trial value fits
    // one bit more than the divisor.
    always_comb begin
        n_trial = {r_rem, r_bits[QUO_W-1]};
        n_diff  = n_trial - {1'b0, r_divisor};
        n_ge    = n_trial >= {1'b0, r_divisor};
        n_rem   = n_ge ? n_diff[OHM_W-1:0] : n_trial[OHM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == DIV_CNT_W'(1)) && !i_req.start;
            if (i_req.start) begin
                r_cnt <= i_req.short_quo ? DIV_CNT_W'(SHORT_QUO_W) : DIV_CNT_W'(QUO_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_divisor <= i_req.divisor;
            r_quo     <= '0;
            if (i_req.short_quo) begin
                r_rem  <= OHM_W'(i_req.dividend[SHORT_REM_HI-1:SHORT_QUO_W]);
                r_bits <= {i_req.dividend[SHORT_QUO_W-1:0], {(QUO_W-SHORT_QUO_W){1'b0}}};
            end else begin
                r_rem  <= OHM_W'(i_req.dividend[PROD_W-1:QUO_W]);
                r_bits <= i_req.dividend[QUO_W-1:0];
            end
        end else if (r_cnt != '0) begin
            r_rem  <= n_rem;
            r_bits <= {r_bits[QUO_W-2:0], 1'b0};
            r_quo  <= {r_quo[QUO_W-2:0], n_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: hdl/adc_scan_filter_ntc_convert.sv
// Top level of the converter scan: per-channel filters, NTC interpolation and divider scaling.
// Depends on asf_pkg, asf_mul and asf_div.
//
//   Channel  Handshake                        Payload
//   sample   i_sample_valid / o_sample_ready  i_sample
//   result   o_result_valid / i_result_ready  o_channel, o_filtered_sample, o_measurement,
//                                             o_end_of_scan, o_next_select
//   config   i_cfg_valid / o_cfg_ready        i_cfg_index, i_cfg_data
//
// One sample beat is worked at a time. A voltage channel runs two serial multiplies and a
// serial divide; a saturating divider skips the divide. The temperature channel walks the
// table one point a cycle and, when it interpolates, then runs a multiply and a divide;
// below the table, at its last point or on a flat segment it skips them. The next sample
// beat is accepted in the cycle after the result is loaded into the output register.
// Reset is synchronous and active low; it restores the configuration, clears all filters
// and restarts the scan at channel 0. The result sits in an output register, so a stalled
// result does not block the next sample beat; only its delivery waits for the register.

module adc_scan_filter_ntc_convert (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_sample_valid,
    output logic                          o_sample_ready,
    input  logic [asf_pkg::SAMPLE_W-1:0]  i_sample,

    output logic                          o_result_valid,
    input  logic                          i_result_ready,
    output logic [asf_pkg::CH_OUT_W-1:0]  o_channel,
    output logic [asf_pkg::SAMPLE_W-1:0]  o_filtered_sample,
    output logic [asf_pkg::MEAS_W-1:0]    o_measurement,
    output logic                          o_end_of_scan,
    output logic [asf_pkg::SEL_W-1:0]     o_next_select,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [asf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [asf_pkg::OHM_W-1:0]     i_cfg_data
);
    import asf_pkg::*;

    t_state r_state;
    t_state n_state;

    // Configuration registers.
    logic [FS_W-1:0]  r_full_scale;
    logic [OHM_W-1:0] r_dim_top;
    logic [OHM_W-1:0] r_dim_bottom;
    logic [OHM_W-1:0] r_sup_top;
    logic [OHM_W-1:0] r_sup_bottom;

    // Filter state and scan position.
    logic [ACC_W-1:0]  r_chan_filt [NUM_CHANNELS];
    logic [TEMP_W-1:0] r_temp;
    logic [SCAN_W-1:0] r_scan;

    // Working registers of the item in flight.
    logic [SCAN_W-1:0]   r_ch;
    logic [SAMPLE_W-1:0] r_filt;
    logic [SEG_W-1:0]    r_seg;
    logic [TENTHS_W-1:0] r_lookup;
    logic [MEAS_W-1:0]   r_meas;

    // Output register.
    logic                r_out_valid;
    logic [CH_OUT_W-1:0] r_out_channel;
    logic [SAMPLE_W-1:0] r_out_filt;
    logic [MEAS_W-1:0]   r_out_meas;
    logic                r_out_eos;
    logic [SEL_W-1:0]    r_out_select;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic                sample_accept;
    logic                out_free;
    logic [ACC_W-1:0]    n_acc;
    logic [SCAN_W-1:0]   n_scan;
    logic [TEMP_W-1:0]   n_temp;
    logic [SUM_W-1:0]    res_sum;
    logic [OHM_W-1:0]    res_bottom;
    logic                volt_sat;
    logic                ch_eos;
    logic [SCAN_W-1:0]   ch_next;

    // Table walk signals.
    logic [SEG_W-1:0]    seg_next;
    logic [COUNT_W-1:0]  cnt_seg;
    logic [COUNT_W-1:0]  cnt_next;
    logic [COUNT_W-1:0]  span;
    logic [TENTHS_W-1:0] rise;
    logic [SAMPLE_W-1:0] offset;
    logic                s_below;
    logic                s_at_last;
    logic                s_advance;
    logic                s_flat;

    assign o_sample_ready = (r_state == ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign sample_accept  = i_sample_valid && o_sample_ready;
    assign out_free       = !r_out_valid || i_result_ready;

    // First-order filter of the scanned channel: acc - acc/8 + sample.
    always_comb begin
        n_acc  = ACC_W'(r_chan_filt[r_scan] - (r_chan_filt[r_scan] >> FILT_SHIFT) +
                        ACC_W'(i_sample));
        n_scan = (r_scan == LAST_CHANNEL) ? SCAN_W'(0) : r_scan + SCAN_W'(1);
        n_temp = TEMP_W'(r_temp - (r_temp >> TEMP_SHIFT) + TEMP_W'(r_lookup));
    end

    // Channel 4 uses the supply divider, every other voltage channel the dimming one.
    always_comb begin
        if (r_ch == SUPPLY_CHANNEL) begin
            res_sum    = SUM_W'(r_sup_top) + SUM_W'(r_sup_bottom);
            res_bottom = r_sup_bottom;
        end else begin
            res_sum    = SUM_W'(r_dim_top) + SUM_W'(r_dim_bottom);
            res_bottom = r_dim_bottom;
        end
        // The quotient exceeds 16 bits exactly when the dividend's upper part reaches the
        // divisor; a zero bottom resistor lands here as well.
        volt_sat = OHM_W'(mul_rsp.product[PROD_W-1:QUO_W]) >= res_bottom;
        ch_eos   = (r_ch == LAST_CHANNEL);
        ch_next  = ch_eos ? SCAN_W'(0) : r_ch + SCAN_W'(1);
    end

    // The walk moves one table point per cycle while the filtered value has reached the next
    // point; the segment it stops on is interpolated unless flat, below the table or the last.
    always_comb begin
        seg_next  = r_seg + SEG_W'(1);
        cnt_seg   = ntc_count(r_seg);
        cnt_next  = ntc_count(seg_next);
        span      = cnt_next - cnt_seg;
        rise      = ntc_tenths(seg_next) - ntc_tenths(r_seg);
        offset    = r_filt - cnt_seg;
        s_below   = (r_seg == SEG_W'(0)) && (r_filt < cnt_seg);
        s_at_last = (r_seg == SEG_LAST);
        s_advance = !s_at_last && (r_filt >= cnt_next);
        s_flat    = (span == '0);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (sample_accept) begin
                    n_state = (r_scan == SCAN_W'(0)) ? ST_SEARCH : ST_VOLT_MUL1;
                end
            end
            ST_SEARCH: begin
                if (s_below || s_at_last) begin
                    n_state = ST_TEMP;
                end else if (s_advance) begin
                    n_state = ST_SEARCH;
                end else if (s_flat) begin
                    n_state = ST_TEMP;
                end else begin
                    n_state = ST_INTERP_MUL;
                end
            end
            ST_INTERP_MUL: begin
                if (mul_rsp.done) begin
                    n_state = ST_INTERP_DIV;
                end
            end
            ST_INTERP_DIV: begin
                if (div_rsp.done) begin
                    n_state = ST_TEMP;
                end
            end
            ST_TEMP: begin
                n_state = ST_FINISH;
            end
            ST_VOLT_MUL1: begin
                if (mul_rsp.done) begin
                    n_state = ST_VOLT_MUL2;
                end
            end
            ST_VOLT_MUL2: begin
                if (mul_rsp.done) begin
                    n_state = volt_sat ? ST_FINISH : ST_VOLT_DIV;
                end
            end
            ST_VOLT_DIV: begin
                if (div_rsp.done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Unit requests. Each unit is started in the cycle that leaves the previous step,
    // so no cycle is lost between the multiplies and the divide.
    always_comb begin
        mul_req = '0;
        div_req = '0;
        case (r_state)
            ST_IDLE: begin
                if (sample_accept && (r_scan != SCAN_W'(0))) begin
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = SUM_W'(n_acc[ACC_W-1:FILT_SHIFT]);
                    mul_req.mplier = MPLIER_W'(r_full_scale);
                end
            end
            ST_SEARCH: begin
                if (!s_below && !s_at_last && !s_advance && !s_flat) begin
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = SUM_W'(offset);
                    mul_req.mplier = MPLIER_W'(rise);
                end
            end
            ST_INTERP_MUL: begin
                if (mul_rsp.done) begin
                    div_req.start     = 1'b1;
                    div_req.short_quo = 1'b1;
                    div_req.dividend  = mul_rsp.product;
                    div_req.divisor   = OHM_W'(span);
                end
            end
            ST_VOLT_MUL1: begin
                // Scaled converter value: filtered * full scale / 4096.
                if (mul_rsp.done) begin
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = res_sum;
                    mul_req.mplier = mul_rsp.product[FS_W+SAMPLE_W-1:SAMPLE_W];
                end
            end
            ST_VOLT_MUL2: begin
                if (mul_rsp.done && !volt_sat) begin
                    div_req.start     = 1'b1;
                    div_req.short_quo = 1'b0;
                    div_req.dividend  = mul_rsp.product;
                    div_req.divisor   = res_bottom;
                end
            end
            default: begin
                mul_req = '0;
                div_req = '0;
            end
        endcase
    end

    // Control state, configuration and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_full_scale <= RST_FULL_SCALE;
            r_dim_top    <= RST_DIM_TOP;
            r_dim_bottom <= RST_DIM_BOTTOM;
            r_sup_top    <= RST_SUP_TOP;
            r_sup_bottom <= RST_SUP_BOTTOM;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_chan_filt[i] <= '0;
            end
            r_temp       <= '0;
            r_scan       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FULL_SCALE: r_full_scale <= i_cfg_data[FS_W-1:0];
                    CFG_DIM_TOP:    r_dim_top    <= i_cfg_data;
                    CFG_DIM_BOTTOM: r_dim_bottom <= i_cfg_data;
                    CFG_SUP_TOP:    r_sup_top    <= i_cfg_data;
                    CFG_SUP_BOTTOM: r_sup_bottom <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (sample_accept) begin
                r_chan_filt[r_scan] <= n_acc;
                r_scan              <= n_scan;
            end

            if (r_state == ST_TEMP) begin
                r_temp <= n_temp;
            end

            if ((r_state == ST_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working and output payload registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (sample_accept) begin
                    r_ch   <= r_scan;
                    r_filt <= n_acc[ACC_W-1:FILT_SHIFT];
                    r_seg  <= '0;
                end
            end
            ST_SEARCH: begin
                if (s_below) begin
                    r_lookup <= '0;
                end else if (s_at_last) begin
                    r_lookup <= ntc_tenths(SEG_LAST);
                end else if (s_advance) begin
                    r_seg <= seg_next;
                end else if (s_flat) begin
                    r_lookup <= ntc_tenths(r_seg);
                end
            end
            ST_INTERP_DIV: begin
                if (div_rsp.done) begin
                    r_lookup <= TENTHS_W'(ntc_tenths(r_seg) + div_rsp.quotient[TENTHS_W-1:0]);
                end
            end
            ST_TEMP: begin
                r_meas <= MEAS_W'(n_temp[TEMP_W-1:TEMP_SHIFT]);
            end
            ST_VOLT_MUL2: begin
                if (mul_rsp.done && volt_sat) begin
                    r_meas <= MEAS_MAX;
                end
            end
            ST_VOLT_DIV: begin
                if (div_rsp.done) begin
                    r_meas <= div_rsp.quotient;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    r_out_channel <= CH_OUT_W'(r_ch);
                    r_out_filt    <= r_filt;
                    r_out_meas    <= r_meas;
                    r_out_eos     <= ch_eos;
                    r_out_select  <= SEL_W'(1) << ch_next;
                end
            end
            default: begin
            end
        endcase
    end

    asf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    asf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_result_valid    = r_out_valid;
    assign o_channel         = r_out_channel;
    assign o_filtered_sample = r_out_filt;
    assign o_measurement     = r_out_meas;
    assign o_end_of_scan     = r_out_eos;
    assign o_next_select     = r_out_select;

endmodule
